// ----- design/rmh_pkg.sv -----
// Package for the multi-modulus rolling window hash.
// Holds sizes, register indexes and the controller/datapath command types.
// No dependencies.
package rmh_pkg;

    localparam int NUM_HASHES   = 3;
    localparam int MAX_WINDOW   = 32;
    localparam int MODULUS_BITS = 27;
    localparam int LANES        = 3;

    // field widths fixed by the register and stream definitions
    localparam int ALPHA_W = 9;
    localparam int WLEN_W  = 6;
    localparam int MOD_W   = 28;
    localparam int DROP_W  = 27;
    localparam int SYM_W   = 8;
    localparam int HASH_W  = 27;
    localparam int CFG_W   = 28;
    localparam int IDX_W   = 3;

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);

    // widest operand fed into the serial reducer: h*alpha + symbol
    localparam int PROD_W    = MODULUS_BITS + ALPHA_W + 1;
    localparam int RED_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(RED_STEPS);

    localparam logic [MOD_W-1:0] MOD_CAP = MOD_W'(1) << MODULUS_BITS;

    typedef enum logic [IDX_W-1:0] {
        REG_ALPHA_SIZE    = 3'd0,
        REG_WINDOW_LEN    = 3'd1,
        REG_MODULUS_0     = 3'd2,
        REG_MODULUS_1     = 3'd3,
        REG_MODULUS_2     = 3'd4,
        REG_DROP_FACTOR_0 = 3'd5,
        REG_DROP_FACTOR_1 = 3'd6,
        REG_DROP_FACTOR_2 = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic accept;   // capture the input word
        logic load;     // form the products, prime the reducers
        logic step;     // one reduction bit per operand in each lane
        logic commit;   // update state and present the result
    } t_cmd;

    typedef struct packed {
        logic relevant;
    } t_status;

endpackage

// ----- design/rmh_ctrl.sv -----
// Sequencer for the rolling hash: accept, load, serial reduction, commit.
// Depends on rmh_pkg.
module rmh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  rmh_pkg::t_status i_status,
    output rmh_pkg::t_cmd    o_cmd
);
    import rmh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RED, S_DONE} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_valid;
    logic             w_can_commit;

    assign w_can_commit = !r_valid || i_m_tready;
    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.step   = (r_state == S_RED);
        o_cmd.commit = (r_state == S_DONE) && w_can_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_cmd.commit)
                r_valid <= 1'b1;
            else if (i_m_tready)
                r_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_count <= '0;
                    // an irrelevant symbol skips the reduction and only clears
                    r_state <= i_status.relevant ? S_RED : S_DONE;
                end
                S_RED: begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_count == CNT_W'(RED_STEPS - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_can_commit) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a finished word never overwrites one still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_valid || i_m_tready))
        else $error("result committed over an untaken word");

    // load always follows an accepted word
    a_load_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.load)
        else $error("load did not follow accept");

    // a commit raises the output valid
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_m_tvalid)
        else $error("commit did not present a result");

    // the reducer runs the full bit count before commit
    a_red_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED && r_count != CNT_W'(RED_STEPS - 1)) |=> (r_state == S_RED))
        else $error("reduction cut short");
`endif

endmodule

// ----- design/rmh_lane.sv -----
// One hash lane: product registers, two bit-serial modulo reducers, combine.
// Depends on rmh_pkg.
module rmh_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rmh_pkg::t_cmd               i_cmd,
    input  logic                        i_clear,
    input  logic [rmh_pkg::ALPHA_W-1:0] i_alpha,
    input  logic [rmh_pkg::MOD_W-1:0]   i_modulus,
    input  logic [rmh_pkg::DROP_W-1:0]  i_drop,
    input  logic [rmh_pkg::SYM_W-1:0]   i_sym,
    input  logic [rmh_pkg::SYM_W-1:0]   i_oldest,
    output logic [rmh_pkg::HASH_W-1:0]  o_hash
);
    import rmh_pkg::*;

    logic [MODULUS_BITS-1:0] r_h;
    logic [PROD_W-1:0]       r_ax, r_bx;
    logic [MODULUS_BITS-1:0] r_ra, r_rb;
    logic [MOD_W-1:0]        r_m;
    logic                    r_zero;

    logic [MOD_W-1:0]        w_ta, w_tb;
    logic [MODULUS_BITS-1:0] w_na, w_nb, w_diff;

    // restoring step: remainder stays below m, so one subtract per bit
    assign w_ta = {r_ra, r_ax[PROD_W-1]};
    assign w_tb = {r_rb, r_bx[PROD_W-1]};
    assign w_na = (w_ta >= r_m) ? MODULUS_BITS'(w_ta - r_m) : MODULUS_BITS'(w_ta);
    assign w_nb = (w_tb >= r_m) ? MODULUS_BITS'(w_tb - r_m) : MODULUS_BITS'(w_tb);

    assign w_diff = (r_ra >= r_rb) ? (r_ra - r_rb)
                                   : MODULUS_BITS'(MOD_W'(r_ra) + r_m - MOD_W'(r_rb));

    assign o_hash = HASH_W'(r_h);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax   <= PROD_W'(r_h) * PROD_W'(i_alpha) + PROD_W'(i_sym);
            r_bx   <= PROD_W'(i_oldest) * PROD_W'(i_drop);
            r_ra   <= '0;
            r_rb   <= '0;
            r_m    <= (i_modulus > MOD_CAP) ? MOD_CAP : i_modulus;
            r_zero <= (i_modulus < MOD_W'(2));
        end else if (i_cmd.step) begin
            r_ax <= r_ax << 1;
            r_bx <= r_bx << 1;
            r_ra <= w_na;
            r_rb <= w_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
        end else if (i_cmd.commit) begin
            r_h <= (i_clear || r_zero) ? '0 : w_diff;
        end
    end

endmodule

// ----- design/rmh_datapath.sv -----
// Datapath: configuration registers, symbol ring, fill count and hash lanes.
// Depends on rmh_pkg and rmh_lane.
module rmh_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rmh_pkg::t_cmd                     i_cmd,
    output rmh_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  rmh_pkg::t_reg_idx                 i_cfg_index,
    input  logic [rmh_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [rmh_pkg::SYM_W-1:0]         i_symbol,
    input  logic                              i_symbol_relevant,
    output logic [rmh_pkg::LANES*rmh_pkg::HASH_W-1:0] o_hashes,
    output logic                              o_window_full
);
    import rmh_pkg::*;

    logic [ALPHA_W-1:0] r_alpha;
    logic [WLEN_W-1:0]  r_wlen;
    logic [MOD_W-1:0]   r_mod  [LANES];
    logic [DROP_W-1:0]  r_drop [LANES];

    logic [SYM_W-1:0]   r_sym;
    logic               r_rel;
    logic [SYM_W-1:0]   r_ring [MAX_WINDOW];
    logic [SLOT_W-1:0]  r_oldest;
    logic [FILL_W-1:0]  r_fill;
    logic               r_full;

    logic [WLEN_W-1:0]  w_win;
    logic [FILL_W-1:0]  n_fill;
    logic [SLOT_W:0]    w_slot_inc;

    assign o_status.relevant = r_rel;
    assign o_window_full     = r_full;

    always_comb begin
        if (r_wlen == '0)
            w_win = WLEN_W'(1);
        else if (r_wlen > WLEN_W'(MAX_WINDOW))
            w_win = WLEN_W'(MAX_WINDOW);
        else
            w_win = r_wlen;
    end

    assign w_slot_inc = {1'b0, r_oldest} + (SLOT_W + 1)'(1);
    assign n_fill     = (r_fill < FILL_W'(MAX_WINDOW)) ? r_fill + FILL_W'(1) : r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_W'(4);
            r_wlen  <= WLEN_W'(12);
            for (int i = 0; i < LANES; i++) begin
                r_mod[i]  <= MOD_W'(16777216);
                r_drop[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ALPHA_SIZE:    r_alpha   <= i_cfg_data[ALPHA_W-1:0];
                REG_WINDOW_LEN:    r_wlen    <= i_cfg_data[WLEN_W-1:0];
                REG_MODULUS_0:     r_mod[0]  <= i_cfg_data[MOD_W-1:0];
                REG_MODULUS_1:     r_mod[1]  <= i_cfg_data[MOD_W-1:0];
                REG_MODULUS_2:     r_mod[2]  <= i_cfg_data[MOD_W-1:0];
                REG_DROP_FACTOR_0: r_drop[0] <= i_cfg_data[DROP_W-1:0];
                REG_DROP_FACTOR_1: r_drop[1] <= i_cfg_data[DROP_W-1:0];
                REG_DROP_FACTOR_2: r_drop[2] <= i_cfg_data[DROP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sym <= i_symbol;
            r_rel <= i_symbol_relevant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WINDOW; i++) r_ring[i] <= '0;
            r_oldest <= '0;
            r_fill   <= '0;
            r_full   <= 1'b0;
        end else if (i_cmd.commit) begin
            if (!r_rel) begin
                for (int i = 0; i < MAX_WINDOW; i++) r_ring[i] <= '0;
                r_oldest <= '0;
                r_fill   <= '0;
                r_full   <= 1'b0;
            end else begin
                r_ring[r_oldest] <= r_sym;
                // a slot past a shortened window wraps to zero here
                r_oldest <= (w_slot_inc >= (SLOT_W + 1)'(w_win)) ? '0 : w_slot_inc[SLOT_W-1:0];
                r_fill   <= n_fill;
                r_full   <= (n_fill >= FILL_W'(w_win));
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        if (g < NUM_HASHES) begin : g_on
            rmh_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (i_cmd),
                .i_clear   (!r_rel),
                .i_alpha   (r_alpha),
                .i_modulus (r_mod[g]),
                .i_drop    (r_drop[g]),
                .i_sym     (r_sym),
                .i_oldest  (r_ring[r_oldest]),
                .o_hash    (o_hashes[g*HASH_W +: HASH_W])
            );
        end else begin : g_off
            assign o_hashes[g*HASH_W +: HASH_W] = '0;
        end
    end

endmodule

// ----- design/multi_modulus_rolling_window_hash.sv -----
// Top level of the multi-modulus rolling window hash.
// Depends on rmh_pkg, rmh_ctrl, rmh_datapath (and rmh_lane below it).
//
// Rabin-Karp rolling hash over the last window_len symbols in three lanes,
// each with its own run-time modulus. One symbol word in gives one result
// word out. A symbol passes from acceptance to result through capture,
// forming the products h*alpha+symbol and oldest*drop_factor, the
// bit-serial modulo reducers (one bit per cycle per operand, the
// reducers of all lanes run side by side), and combine and commit.
// A word with tuser low skips the reducers.
// A new word is accepted once the previous one is committed; the result
// sits in the output register until taken, and a commit waits if the
// previous result has not been taken. A word with tuser low clears the
// ring and hashes and returns zero hashes with window_full low.
// Configuration writes are always ready and must come while idle.
module multi_modulus_rolling_window_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // stream in
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [7:0] symbol
    input  logic                       i_s_tuser,   // [0] symbol_relevant
    // stream out
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [87:0]                o_m_tdata,   // [26:0] hash_0, [53:27] hash_1,
                                                    // [80:54] hash_2, [87:81] zero
    output logic                       o_m_tuser,   // [0] window_full
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  rmh_pkg::t_reg_idx          i_cfg_index,
    input  logic [rmh_pkg::CFG_W-1:0]  i_cfg_data
);
    import rmh_pkg::*;

    t_cmd                      w_cmd;
    t_status                   w_status;
    logic [LANES*HASH_W-1:0]   w_hashes;

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {(88 - LANES*HASH_W)'(0), w_hashes};

    rmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rmh_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_symbol          (i_s_tdata),
        .i_symbol_relevant (i_s_tuser),
        .o_hashes          (w_hashes),
        .o_window_full     (o_m_tuser)
    );

endmodule
